### rtl/core/brp_pkg.sv
// ----------------------------------------------------------------------------
// brp_pkg
// Shared types and register indexes of the bitmap rectangle placer.
// ----------------------------------------------------------------------------
package brp_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	localparam logic [CFG_IDX_W-1:0] REG_AREA_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AREA_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PACK_ENABLE = 2'd2;

	typedef struct packed {
		logic [9:0] rect_width;
		logic [9:0] rect_height;
		logic [8:0] source_left;
		logic [8:0] source_top;
		logic       last_in_batch;
	} rect_req_t;

	typedef struct packed {
		logic [9:0]  placed_left;
		logic [9:0]  placed_top;
		logic [10:0] placed_right;
		logic [10:0] placed_bottom;
		logic        no_room;
		logic [10:0] extent_right;
		logic [10:0] extent_bottom;
	} rect_rsp_t;

endpackage

### rtl/core/brp_ram.sv
// ----------------------------------------------------------------------------
// brp_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module brp_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

### rtl/core/bitmap_rectangle_placer_unit.sv
// ----------------------------------------------------------------------------
// bitmap_rectangle_placer_unit
// Places rectangles into an occupancy bitmap held in one RAM.
// ----------------------------------------------------------------------------
// One request at a time. With packing enabled, for each row below the height
// limit the unit ORs the footprint's rows into a column register (fh * WORDS
// reads), then walks the columns one per cycle (up to area width) looking for
// the first free run; each row candidate then passes ST_SQ and ST_CMP for the
// distance compare. Marking reads and writes back each word of each footprint
// row. All of this shares the one RAM port. After reset and after the last
// request of a batch the map is swept to zero, all WORDS*AREA_MAX_H words (4096
// with the defaults), during which no request is taken. With packing disabled
// the footprint is marked at the source position without a search.
module bitmap_rectangle_placer_unit #(
	parameter int AREA_MAX_W = 512,
	parameter int AREA_MAX_H = 512,
	parameter int GAP        = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [brp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [brp_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  brp_pkg::rect_req_t               in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output brp_pkg::rect_rsp_t               out_data
);
	import brp_pkg::*;

	localparam int WORDS = (AREA_MAX_W + 63) / 64;
	localparam int DEPTH = WORDS * AREA_MAX_H;
	localparam int AW    = $clog2(DEPTH);
	localparam int KW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int CB    = $clog2(WORDS * 64);
	localparam int PW    = $clog2(AREA_MAX_W + AREA_MAX_H + 2048 + 4 * GAP + 2) + 1;
	localparam int MW    = (AREA_MAX_W > AREA_MAX_H) ? $clog2(AREA_MAX_W) : $clog2(AREA_MAX_H);
	localparam int HW    = 2 * MW + 1;

	typedef enum logic [10:0] {
		ST_CLEAR   = 11'b00000000001,
		ST_IDLE    = 11'b00000000010,
		ST_ROW     = 11'b00000000100,
		ST_GATHER  = 11'b00000001000,
		ST_DRAIN   = 11'b00000010000,
		ST_SCAN    = 11'b00000100000,
		ST_SQ      = 11'b00001000000,
		ST_CMP     = 11'b00010000000,
		ST_MARK_RD = 11'b00100000000,
		ST_MARK_WR = 11'b01000000000,
		ST_DONE    = 11'b10000000000
	} state_t;

	state_t state_q;

	logic [9:0] area_width_q, area_height_q;
	logic       pack_enable_q;

	logic [9:0]  w_q, h_q;
	logic        last_q;
	logic [PW-1:0] aw_q, ah_q, fw_q, fh_q;
	logic [PW-1:0] y_q, r_q, c_q, run_q, cx_q, px_q, py_q, mr_q;
	logic [KW-1:0] k_q;
	logic          found_q;
	logic [HW-1:0] best_q, xx_q;
	logic [WORDS*64-1:0] col_q;
	logic          rd_v_s1;
	logic [KW-1:0] rk_s1;
	logic [AW-1:0] clr_q;
	logic [10:0]   ext_r_q, ext_b_q;
	logic          out_valid_q;
	rect_rsp_t     out_q;

	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [63:0]   ram_wdata, ram_rdata;

	logic [PW-1:0] aw_n, ah_n, run_n;
	logic [HW-1:0] hyp;
	logic [63:0]   mask;
	logic [PW-1:0] left, top;
	logic [10:0]   right, bottom;
	logic          k_last;

	brp_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_map (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign aw_n = (PW'(area_width_q) > PW'(AREA_MAX_W)) ? PW'(AREA_MAX_W) : PW'(area_width_q);
	assign ah_n = (PW'(area_height_q) > PW'(AREA_MAX_H)) ? PW'(AREA_MAX_H) : PW'(area_height_q);
	assign k_last = (32'(k_q) == WORDS - 1);
	assign run_n  = col_q[c_q[CB-1:0]] ? '0 : run_q + 1'b1;
	assign hyp    = xx_q + HW'(y_q[MW-1:0]) * HW'(y_q[MW-1:0]);

	// footprint columns of word k_q, clipped to the area
	always_comb begin
		logic [PW-1:0] colx;
		for (int b = 0; b < 64; b++) begin
			colx = PW'({k_q, 6'(b)});
			mask[b] = (colx >= px_q) && (colx < px_q + fw_q) && (colx < aw_q);
		end
	end

	assign left   = px_q + PW'(GAP);
	assign top    = py_q + PW'(GAP);
	assign right  = 11'(left + PW'(w_q));
	assign bottom = 11'(top + PW'(h_q));

	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = ram_rdata | mask;
		ram_addr  = AW'(mr_q) * AW'(WORDS) + AW'(k_q);
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_wdata = '0;
				ram_addr  = clr_q;
			end
			ST_GATHER: begin
				ram_addr = AW'(y_q + r_q) * AW'(WORDS) + AW'(k_q);
			end
			ST_MARK_WR: begin
				ram_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_width_q  <= 10'd512;
			area_height_q <= 10'd512;
			pack_enable_q <= 1'b1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_AREA_WIDTH:  area_width_q  <= cfg_data;
				REG_AREA_HEIGHT: area_height_q <= cfg_data;
				REG_PACK_ENABLE: pack_enable_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// column register fill, one word behind the read
	always_ff @(posedge clk) begin
		if (state_q == ST_ROW) begin
			col_q <= '0;
		end else if (rd_v_s1) begin
			col_q[rk_s1*64 +: 64] <= col_q[rk_s1*64 +: 64] | ram_rdata;
		end
		rk_s1 <= k_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			rd_v_s1     <= 1'b0;
			ext_r_q     <= '0;
			ext_b_q     <= '0;
			found_q     <= 1'b0;
		end else begin
			rd_v_s1 <= (state_q == ST_GATHER);
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == DEPTH - 1) begin
						clr_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						w_q    <= in_data.rect_width;
						h_q    <= in_data.rect_height;
						last_q <= in_data.last_in_batch;
						aw_q   <= aw_n;
						ah_q   <= ah_n;
						fw_q   <= PW'(in_data.rect_width) + PW'(2 * GAP);
						fh_q   <= PW'(in_data.rect_height) + PW'(2 * GAP);
						y_q    <= '0;
						k_q    <= '0;
						if (pack_enable_q) begin
							found_q <= 1'b0;
							state_q <= ST_ROW;
						end else begin
							found_q <= 1'b1;
							px_q    <= PW'(in_data.source_left);
							py_q    <= PW'(in_data.source_top);
							mr_q    <= PW'(in_data.source_top);
							state_q <= ST_MARK_RD;
						end
					end
				end
				ST_ROW: begin
					r_q <= '0;
					k_q <= '0;
					if (y_q + fh_q < ah_q) begin
						state_q <= (fh_q == '0) ? ST_DRAIN : ST_GATHER;
					end else if (found_q) begin
						mr_q    <= py_q;
						state_q <= ST_MARK_RD;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_GATHER: begin
					k_q <= k_q + 1'b1;
					if (k_last) begin
						k_q <= '0;
						r_q <= r_q + 1'b1;
						if (r_q + 1'b1 == fh_q) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					c_q   <= '0;
					run_q <= '0;
					if (fw_q == '0) begin
						cx_q    <= '0;
						if (aw_q != '0) begin
							state_q <= ST_SQ;
						end else begin
							y_q     <= y_q + 1'b1;
							state_q <= ST_ROW;
						end
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (c_q + 1'b1 >= aw_q) begin
						y_q     <= y_q + 1'b1;
						state_q <= ST_ROW;
					end else if (run_n == fw_q) begin
						cx_q    <= c_q + 1'b1 - fw_q;
						state_q <= ST_SQ;
					end else begin
						c_q   <= c_q + 1'b1;
						run_q <= run_n;
					end
				end
				ST_SQ: begin
					xx_q    <= HW'(cx_q[MW-1:0]) * HW'(cx_q[MW-1:0]);
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (!found_q || hyp < best_q) begin
						best_q  <= hyp;
						px_q    <= cx_q;
						py_q    <= y_q;
						found_q <= 1'b1;
					end
					y_q     <= y_q + 1'b1;
					state_q <= ST_ROW;
				end
				ST_MARK_RD: begin
					if (mr_q < ah_q && mr_q < py_q + fh_q) begin
						state_q <= ST_MARK_WR;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_MARK_WR: begin
					k_q     <= k_q + 1'b1;
					state_q <= ST_MARK_RD;
					if (k_last) begin
						k_q  <= '0;
						mr_q <= mr_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (!(out_valid_q && out_stall)) begin
						out_valid_q <= 1'b1;
						if (found_q) begin
							out_q.placed_left   <= left[9:0];
							out_q.placed_top    <= top[9:0];
							out_q.placed_right  <= right;
							out_q.placed_bottom <= bottom;
							out_q.no_room       <= 1'b0;
							out_q.extent_right  <= (right > ext_r_q) ? right : ext_r_q;
							out_q.extent_bottom <= (bottom > ext_b_q) ? bottom : ext_b_q;
							if (!last_q && right > ext_r_q) ext_r_q <= right;
							if (!last_q && bottom > ext_b_q) ext_b_q <= bottom;
						end else begin
							out_q.placed_left   <= '0;
							out_q.placed_top    <= '0;
							out_q.placed_right  <= '0;
							out_q.placed_bottom <= '0;
							out_q.no_room       <= 1'b1;
							out_q.extent_right  <= ext_r_q;
							out_q.extent_bottom <= ext_b_q;
						end
						if (last_q) begin
							ext_r_q <= '0;
							ext_b_q <= '0;
							clr_q   <= '0;
							state_q <= ST_CLEAR;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
